// ===== src/hcbp_pkg.sv =====
package hcbp_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned CodeW = 32;
  localparam int unsigned LenW  = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned VbW   = 4;
  localparam int unsigned AccW  = CodeW + ByteW;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       hit;
  } stage_t;

endpackage

// ===== src/hcbp_if.sv =====
interface hcbp_req_if;
  import hcbp_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [SymW-1:0]  symbol;
  logic [CodeW-1:0] code_bits;
  logic [LenW-1:0]  code_length;
  modport source (output valid, operation, symbol, code_bits, code_length, input ready);
  modport sink (input valid, operation, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_res_if;
  import hcbp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [VbW-1:0]   valid_bits;
  logic             last;
  modport source (output valid, out_byte, valid_bits, last, input ready);
  modport sink (input valid, out_byte, valid_bits, last, output ready);
endinterface

// ===== src/hcbp_table.sv =====
module hcbp_table #(
  parameter int unsigned SYMBOLS = 256,
  parameter int unsigned AW      = 8
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  hcbp_pkg::entry_t  wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output hcbp_pkg::entry_t  rd_data_o
);
  import hcbp_pkg::*;

  entry_t mem [SYMBOLS];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== src/hcbp_pack.sv =====
module hcbp_pack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hcbp_pkg::stage_t stage_i,
  input  hcbp_pkg::entry_t entry_i,
  output logic             fire_o,
  hcbp_res_if.source       res_o
);
  import hcbp_pkg::*;

  logic [ByteW-1:0] pend_q, pend_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [ByteW-1:0] buf_q [4];
  logic [2:0]       bcnt_q;
  logic [VbW-1:0]   vb_q;

  logic [LenW-1:0]  len;
  logic [CodeW-1:0] ca;
  logic [AccW-1:0]  acc;
  logic [AccW-1:0]  sh;
  logic [LenW-1:0]  tot;
  logic [2:0]       nb;
  logic             is_enc, is_flush, emits, buf_free, out_fire;

  always_comb begin
    is_enc   = stage_i.valid && (op_e'(stage_i.op) == OP_ENCODE);
    is_flush = stage_i.valid && (op_e'(stage_i.op) == OP_FLUSH);
    len      = stage_i.hit ? entry_i.len : '0;
    ca       = entry_i.code << (6'd32 - len);
    acc      = {pend_q, {CodeW{1'b0}}} | ({ca, {ByteW{1'b0}}} >> cnt_q);
    tot      = {3'b000, cnt_q} + len;
    nb       = tot[5:3];
    sh       = acc << {nb, 3'b000};
    emits    = (is_enc && (nb != 3'd0)) || (is_flush && (cnt_q != 3'd0));
    out_fire = res_o.valid && res_o.ready;
    buf_free = (bcnt_q == 3'd0) || ((bcnt_q == 3'd1) && res_o.ready);
    fire_o   = stage_i.valid && (!emits || buf_free);
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    if (fire_o && is_enc) begin
      pend_d = sh[AccW-1 -: ByteW];
      cnt_d  = tot[2:0];
    end else if (fire_o && is_flush) begin
      pend_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      bcnt_q <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      if (fire_o && emits) begin
        bcnt_q <= is_flush ? 3'd1 : nb;
      end else if (out_fire) begin
        bcnt_q <= bcnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o && emits) begin
      if (is_flush) begin
        buf_q[0] <= pend_q;
        vb_q     <= {1'b0, cnt_q};
      end else begin
        buf_q[0] <= acc[39:32];
        buf_q[1] <= acc[31:24];
        buf_q[2] <= acc[23:16];
        buf_q[3] <= acc[15:8];
        vb_q     <= VbW'(8);
      end
    end else if (out_fire) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
      buf_q[2] <= buf_q[3];
    end
  end

  assign res_o.valid      = (bcnt_q != 3'd0);
  assign res_o.out_byte   = buf_q[0];
  assign res_o.last       = (bcnt_q == 3'd1);
  assign res_o.valid_bits = res_o.last ? vb_q : VbW'(8);

endmodule

// ===== src/huffman_code_bit_packer.sv =====
// A request and its table entry are registered together into the request stage; the packer then
// registers its bytes into the output buffer. Throughput: one request per cycle while the packer
// can take it; an encode emitting n bytes holds the output buffer until all n are taken, which
// bounds the rate when codes average more than eight bits.
// Reset clears the bit accumulator and pipeline; the code table holds no reset value.
module huffman_code_bit_packer #(
  parameter int unsigned SYMBOLS      = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcbp_req_if.sink  req_i,
  hcbp_res_if.source res_o
);
  import hcbp_pkg::*;

  localparam int unsigned AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned LenCap = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;

  logic    accept, hit, fire;
  logic    s1_valid_q, s1_hit_q;
  logic [1:0] s1_op_q;
  stage_t  stage;
  entry_t  wr_entry, rd_entry;

  assign accept = req_i.valid && req_i.ready;
  assign hit    = ({1'b0, req_i.symbol} < 9'(SYMBOLS));
  assign req_i.ready = !s1_valid_q || fire;

  always_comb begin
    wr_entry.code = req_i.code_bits;
    wr_entry.len  = (req_i.code_length > LenW'(LenCap)) ? LenW'(LenCap) : req_i.code_length;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_LOAD;
      s1_hit_q   <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_op_q    <= req_i.operation;
      s1_hit_q   <= hit;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  assign stage.valid = s1_valid_q;
  assign stage.op    = s1_op_q;
  assign stage.hit   = s1_hit_q;

  hcbp_table #(
    .SYMBOLS (SYMBOLS),
    .AW      (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (accept && hit && (op_e'(req_i.operation) == OP_LOAD)),
    .wr_addr_i (req_i.symbol[AW-1:0]),
    .wr_data_i (wr_entry),
    .rd_en_i   (accept),
    .rd_addr_i (req_i.symbol[AW-1:0]),
    .rd_data_o (rd_entry)
  );

  hcbp_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .entry_i (rd_entry),
    .fire_o  (fire),
    .res_o   (res_o)
  );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import hcbp_pkg::*;

  localparam int unsigned Symbols    = 256;
  localparam int unsigned MaxCodeLen = 32;
  localparam logic [1:0]  OpIgnored  = 2'd3;
  localparam int unsigned IdlePct    = 16;
  localparam int unsigned DrainWait  = 20;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [VbW-1:0]   valid_bits;
    logic             last;
  } packed_byte_t;

  logic clk_i;
  logic rst_ni;

  hcbp_req_if req_if ();
  hcbp_res_if res_if ();

  huffman_code_bit_packer #(
    .SYMBOLS      (Symbols),
    .MAX_CODE_LEN (MaxCodeLen)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  logic [CodeW-1:0] code_tbl [Symbols];
  int unsigned      len_tbl  [Symbols];
  bit               loaded   [Symbols];
  int unsigned      loaded_syms [$];
  logic [ByteW-1:0] pend_byte;
  int unsigned      pend_cnt;
  packed_byte_t     expected_bytes [$];
  int unsigned      error_count;
  bit               src_idle_on;
  bit               sink_idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bits are appended from bit seven downwards; a full byte is emitted at once.
  task automatic predict_request(input logic [1:0] op, input logic [SymW-1:0] sym,
                                 input logic [CodeW-1:0] bits, input logic [LenW-1:0] len);
    packed_byte_t burst [$];
    int unsigned  clen;
    case (op)
      OP_LOAD: begin
        if (sym < Symbols) begin
          clen = (len > MaxCodeLen) ? MaxCodeLen : len;
          if (clen > CodeW) clen = CodeW;
          code_tbl[sym] = bits;
          len_tbl[sym]  = clen;
          if (!loaded[sym]) begin
            loaded[sym] = 1'b1;
            loaded_syms.insert(loaded_syms.size(), 32'(sym));
          end
        end
      end
      OP_ENCODE: begin
        if (sym < Symbols) begin
          for (int i = len_tbl[sym]; i > 0; i--) begin
            pend_byte[ByteW-1-pend_cnt] = code_tbl[sym][i-1];
            pend_cnt++;
            if (pend_cnt == ByteW) begin
              burst.insert(burst.size(), packed_byte_t'{out_byte: pend_byte,
                                                        valid_bits: VbW'(ByteW),
                                                        last: 1'b0});
              pend_byte = '0;
              pend_cnt  = 0;
            end
          end
          if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
          foreach (burst[k]) expected_bytes.insert(expected_bytes.size(), burst[k]);
        end
      end
      OP_FLUSH: begin
        if (pend_cnt != 0) begin
          expected_bytes.insert(expected_bytes.size(),
                                packed_byte_t'{out_byte: pend_byte,
                                               valid_bits: VbW'(pend_cnt), last: 1'b1});
          pend_byte = '0;
          pend_cnt  = 0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input logic [1:0] op, input logic [SymW-1:0] sym,
                              input logic [CodeW-1:0] bits, input logic [LenW-1:0] len);
    while (src_idle_on && $urandom_range(99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.symbol      <= sym;
    req_if.code_bits   <= bits;
    req_if.code_length <= len;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_request(op, sym, bits, len);
    @(negedge clk_i);
  endtask

  function automatic logic [LenW-1:0] random_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    else if (r < 10) return LenW'($urandom_range(63, 33));
    else if (r < 25) return LenW'($urandom_range(32, 11));
    else return LenW'($urandom_range(10, 1));
  endfunction

  task automatic send_random_load();
    send_request(OP_LOAD, SymW'($urandom()), $urandom(), random_length());
  endtask

  task automatic send_random_mix(input int unsigned count);
    int unsigned     r;
    logic [SymW-1:0] sym;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 68) begin
        sym = SymW'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
        send_request(OP_ENCODE, sym, $urandom(), LenW'($urandom()));
      end else if (r < 80) begin
        send_request(OP_FLUSH, SymW'($urandom()), $urandom(), LenW'($urandom()));
      end else if (r < 94) begin
        send_random_load();
      end else begin
        send_request(OpIgnored, SymW'($urandom()), $urandom(), LenW'($urandom()));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(OpIgnored, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(OP_LOAD, 8'd0, 32'h0000_0001, 6'd1);
    send_request(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_request(OP_LOAD, 8'd128, 32'hDEAD_BEEF, 6'd0);
    send_request(OP_LOAD, 8'd7, 32'hA5A5_A5A5, 6'd63);
    send_request(OP_LOAD, 8'd9, 32'h0F0F_00F0, 6'd33);
    send_request(OP_LOAD, 8'd1, 32'h0000_0000, 6'd8);
    send_request(OP_LOAD, 8'd2, 32'h0000_0005, 6'd3);
    send_request(OP_ENCODE, 8'd0, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd255, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd2, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd128, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd7, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd9, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    // Seven bits held ahead of a full-width code give the longest burst.
    send_request(OP_ENCODE, 8'd2, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd2, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd0, 32'h0, 6'd0);
    send_request(OP_ENCODE, 8'd255, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
  endtask

  task automatic test_random_stream();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (40) send_random_load();
    send_random_mix(220);
  endtask

  task automatic test_unbroken_stream();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_random_mix(100);
    send_request(OP_FLUSH, 8'd0, 32'h0, 6'd0);
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= !(sink_idle_on && $urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %h/%0d/%0d", $time,
                 res_if.out_byte, res_if.valid_bits, res_if.last);
        error_count++;
      end else begin
        want = expected_bytes[0];
        expected_bytes.delete(0);
        if (res_if.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                   res_if.out_byte);
          error_count++;
        end
        if (res_if.valid_bits !== want.valid_bits) begin
          $display("%0t: valid_bits expected %0d actual %0d", $time, want.valid_bits,
                   res_if.valid_bits);
          error_count++;
        end
        if (res_if.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, res_if.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_LOAD;
    req_if.symbol      = '0;
    req_if.code_bits   = '0;
    req_if.code_length = '0;
    res_if.ready       = 1'b0;
    pend_byte          = '0;
    pend_cnt           = 0;
    error_count        = 0;
    src_idle_on        = 1'b1;
    sink_idle_on       = 1'b1;
    foreach (loaded[s]) loaded[s] = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_random_stream();
    test_unbroken_stream();
    req_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
